FILE: rtl/ndsp_pkg.sv
`default_nettype none

package ndsp_pkg;

    // Opcodes
    localparam logic [7:0] NULL_DATA_MARK = 8'h6a;
    localparam logic [7:0] LEN_PFX1       = 8'h4c;
    localparam logic [7:0] LEN_PFX2       = 8'h4d;
    localparam logic [7:0] LEN_PFX4       = 8'h4e;
    localparam logic [7:0] NO_DATA_LO     = 8'h4f;
    localparam logic [7:0] NO_DATA_HI     = 8'h60;

    localparam int COUNT_BITS_DEF = 16;
    localparam int OUT_COUNT_W    = 16;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_OPCODE = 4'b0010,
        PH_LEN    = 4'b0100,
        PH_DATA   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic                   is_null_data;
        logic [OUT_COUNT_W-1:0] push_count;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/ndsp_parse.sv
`default_nettype none

module ndsp_parse #(
    parameter int COUNT_BITS = ndsp_pkg::COUNT_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       script_byte,
    input  wire logic             last_byte,
    input  wire logic             empty_script,
    output ndsp_pkg::result_t     result
);

    ndsp_pkg::phase_t        phase_reg, phase_next, phase_upd;
    logic                    failed_reg, failed_next, failed_upd;
    logic [2:0]              len_left_reg, len_left_next, len_left_upd;
    logic [1:0]              len_idx_reg, len_idx_next, len_idx_upd;
    logic [31:0]             data_left_reg, data_left_next, data_left_upd;
    logic [COUNT_BITS-1:0]   count_reg, count_next, count_upd, count_inc;
    logic [ndsp_pkg::OUT_COUNT_W-1:0] count_out;
    logic [2:0]              len_dec;
    logic [31:0]             data_dec;
    logic [31:0]             data_or;
    logic                    ok;

    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_BITS'(1);
    assign len_dec   = len_left_reg - 3'd1;
    assign data_dec  = data_left_reg - 32'd1;
    assign data_or   = data_left_reg | (32'(script_byte) << {len_idx_reg, 3'b000});

    // per-byte state update
    always_comb
    begin
        phase_upd     = phase_reg;
        failed_upd    = failed_reg;
        len_left_upd  = len_left_reg;
        len_idx_upd   = len_idx_reg;
        data_left_upd = data_left_reg;
        count_upd     = count_reg;
        if (!failed_reg)
        begin
            unique case (phase_reg)
                ndsp_pkg::PH_FIRST:
                begin
                    if (script_byte == ndsp_pkg::NULL_DATA_MARK)
                        phase_upd = ndsp_pkg::PH_OPCODE;
                    else
                        failed_upd = 1'b1;
                end
                ndsp_pkg::PH_OPCODE:
                begin
                    if (script_byte > ndsp_pkg::NO_DATA_HI)
                        failed_upd = 1'b1;
                    else if (script_byte < ndsp_pkg::LEN_PFX1)
                    begin
                        count_upd = count_inc;
                        if (script_byte != 8'd0)
                        begin
                            data_left_upd = 32'(script_byte);
                            phase_upd     = ndsp_pkg::PH_DATA;
                        end
                    end
                    else if (script_byte < ndsp_pkg::NO_DATA_LO)
                    begin
                        count_upd     = count_inc;
                        len_left_upd  = (script_byte == ndsp_pkg::LEN_PFX1) ? 3'd1 :
                                        (script_byte == ndsp_pkg::LEN_PFX2) ? 3'd2 : 3'd4;
                        len_idx_upd   = 2'd0;
                        data_left_upd = 32'd0;
                        phase_upd     = ndsp_pkg::PH_LEN;
                    end
                    else
                        count_upd = count_inc;
                end
                ndsp_pkg::PH_LEN:
                begin
                    data_left_upd = data_or;
                    len_idx_upd   = len_idx_reg + 2'd1;
                    len_left_upd  = len_dec;
                    if (len_dec == 3'd0)
                        phase_upd = (data_or != 32'd0) ? ndsp_pkg::PH_DATA
                                                       : ndsp_pkg::PH_OPCODE;
                end
                ndsp_pkg::PH_DATA:
                begin
                    data_left_upd = data_dec;
                    if (data_dec == 32'd0)
                        phase_upd = ndsp_pkg::PH_OPCODE;
                end
                default:
                    failed_upd = 1'b1;
            endcase
        end
    end

    generate
        if (COUNT_BITS > ndsp_pkg::OUT_COUNT_W)
        begin : g_sat
            assign count_out = (|count_upd[COUNT_BITS-1:ndsp_pkg::OUT_COUNT_W]) ?
                               '1 : count_upd[ndsp_pkg::OUT_COUNT_W-1:0];
        end
        else
        begin : g_ext
            assign count_out = ndsp_pkg::OUT_COUNT_W'(count_upd);
        end
    endgenerate

    assign ok = !failed_upd && (phase_upd == ndsp_pkg::PH_OPCODE);

    always_comb
    begin
        if (empty_script || !ok)
        begin
            result.is_null_data = 1'b0;
            result.push_count   = '0;
        end
        else
        begin
            result.is_null_data = 1'b1;
            result.push_count   = count_out;
        end
    end

    // script end or empty script returns to the idle state
    always_comb
    begin
        phase_next     = phase_reg;
        failed_next    = failed_reg;
        len_left_next  = len_left_reg;
        len_idx_next   = len_idx_reg;
        data_left_next = data_left_reg;
        count_next     = count_reg;
        if (step)
        begin
            if (empty_script || last_byte)
            begin
                phase_next     = ndsp_pkg::PH_FIRST;
                failed_next    = 1'b0;
                len_left_next  = 3'd0;
                len_idx_next   = 2'd0;
                data_left_next = 32'd0;
                count_next     = '0;
            end
            else
            begin
                phase_next     = phase_upd;
                failed_next    = failed_upd;
                len_left_next  = len_left_upd;
                len_idx_next   = len_idx_upd;
                data_left_next = data_left_upd;
                count_next     = count_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ndsp_pkg::PH_FIRST;
            failed_reg    <= 1'b0;
            len_left_reg  <= 3'd0;
            len_idx_reg   <= 2'd0;
            data_left_reg <= 32'd0;
            count_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            failed_reg    <= failed_next;
            len_left_reg  <= len_left_next;
            len_idx_reg   <= len_idx_next;
            data_left_reg <= data_left_next;
            count_reg     <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ndsp_out_reg.sv
`default_nettype none

module ndsp_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire ndsp_pkg::result_t d,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output ndsp_pkg::result_t      q
);

    logic              valid_reg, valid_next;
    ndsp_pkg::result_t data_reg;

    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= d;
    end

    assign out_valid = valid_reg;
    assign q         = data_reg;

endmodule

`default_nettype wire

FILE: rtl/null_data_script_push_counter.sv
// Null-data script push counter, one script byte per transfer.
// Path: a last byte is registered in the input register, then the parse logic
//   forms its result into the result register.
// Throughput: one byte per cycle; a script's end waits only while an unread result holds the output.
// Reset: rst_n asynchronous, active low; clears both registers' valid bits
//   and returns the parser to "expecting first byte".
`default_nettype none

module null_data_script_push_counter #(
    parameter int COUNT_BITS = ndsp_pkg::COUNT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  script_byte,
    input  wire logic        last_byte,
    input  wire logic        empty_script,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             is_null_data,
    output logic [15:0]      push_count
);

    // Input register: one accepted transfer waiting for the parser.
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_empty_reg;

    logic        in_accept;
    logic        s1_term;     // this byte ends a script, so it yields a result
    logic        hold;        // result register full and not draining
    logic        advance;     // parser consumes the input register this cycle
    logic        load_out;

    ndsp_pkg::result_t parse_res;
    ndsp_pkg::result_t out_res;

    assign s1_term   = s1_empty_reg || s1_last_reg;
    // Only bytes that produce a result wait on the output side; other
    // bytes keep flowing while a finished result is still pending.
    assign hold      = s1_valid_reg && s1_term && out_valid && !out_ready;
    assign advance   = s1_valid_reg && !hold;
    assign load_out  = advance && s1_term;
    assign in_ready  = !hold;
    assign in_accept = in_valid && in_ready;

    assign s1_valid_next = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg  <= script_byte;
            s1_last_reg  <= last_byte;
            s1_empty_reg <= empty_script;
        end
    end

    // Parse state and per-byte next-state logic; result formed combinationally.
    ndsp_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .script_byte  (s1_byte_reg),
        .last_byte    (s1_last_reg),
        .empty_script (s1_empty_reg),
        .result       (parse_res)
    );

    // Result register decouples the output handshake from the parser.
    ndsp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load_out),
        .d         (parse_res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .q         (out_res)
    );

    assign is_null_data = out_res.is_null_data;
    assign push_count   = out_res.push_count;

`ifndef SYNTH
    // A byte not consumed stays put in the input register.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_byte_reg)
            && $stable(s1_last_reg) && $stable(s1_empty_reg))
        else $error("input register changed while stalled");

    // Failed scripts report a zero count.
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_null_data |-> push_count == 16'd0)
        else $error("nonzero count on non-null-data result");

    // With the result register empty the block always takes input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // A loaded result is shown on the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/null_data_script_push_counter_tb.sv
module null_data_script_push_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD   = 4;
    localparam int unsigned COUNT_MAX    = (1 << ndsp_pkg::COUNT_BITS_DEF) - 1;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned STRETCHES    = 8;
    // extra wait after the last expected result, to catch stray results
    localparam int unsigned DRAIN_CYCLES = 8;

    // ------------------------------------------------------------------
    // Verdict tracker: mirrors the parser state byte by byte and keeps
    // the verdicts still owed by the block, oldest first.
    // ------------------------------------------------------------------
    class null_data_tracker;
        ndsp_pkg::result_t expected_results[$];
        int unsigned       errors      = 0;
        ndsp_pkg::phase_t  parse_phase = ndsp_pkg::PH_FIRST;
        logic [2:0]        len_left    = '0;
        logic [31:0]       data_left   = '0;
        logic [4:0]        len_shift   = '0;
        int unsigned       pushes      = 0;
        logic              failed      = 1'b0;

        function void restart();
            parse_phase = ndsp_pkg::PH_FIRST;
            len_left    = '0;
            data_left   = '0;
            len_shift   = '0;
            pushes      = 0;
            failed      = 1'b0;
        endfunction

        // one accepted input transfer
        function void note_byte(logic [7:0] b, logic last, logic empty);
            ndsp_pkg::result_t r;
            if (empty)
            begin
                // byte and last mark are don't-care; any partial script is dropped
                r = '0;
                expected_results.push_back(r);
                restart();
                return;
            end
            if (!failed)
            begin
                case (parse_phase)
                    ndsp_pkg::PH_FIRST:
                    begin
                        if (b == ndsp_pkg::NULL_DATA_MARK)
                            parse_phase = ndsp_pkg::PH_OPCODE;
                        else
                            failed = 1'b1;
                    end
                    ndsp_pkg::PH_OPCODE:
                    begin
                        if (b > ndsp_pkg::NO_DATA_HI)
                            failed = 1'b1;
                        else
                        begin
                            // every opcode up to the no-data range end is one push
                            if (pushes < COUNT_MAX)
                                pushes++;
                            if (b < ndsp_pkg::LEN_PFX1)
                            begin
                                if (b != 8'h00)
                                begin
                                    data_left   = 32'(b);
                                    parse_phase = ndsp_pkg::PH_DATA;
                                end
                            end
                            else if (b < ndsp_pkg::NO_DATA_LO)
                            begin
                                len_left    = (b == ndsp_pkg::LEN_PFX1) ? 3'd1 :
                                              (b == ndsp_pkg::LEN_PFX2) ? 3'd2 : 3'd4;
                                len_shift   = '0;
                                data_left   = '0;
                                parse_phase = ndsp_pkg::PH_LEN;
                            end
                        end
                    end
                    ndsp_pkg::PH_LEN:
                    begin
                        // little-endian length, shift wraps at 32
                        data_left = data_left | (32'(b) << len_shift);
                        len_shift = len_shift + 5'd8;
                        if (len_left != 0)
                            len_left--;
                        if (len_left == 0)
                            parse_phase = (data_left != 0) ? ndsp_pkg::PH_DATA
                                                           : ndsp_pkg::PH_OPCODE;
                    end
                    ndsp_pkg::PH_DATA:
                    begin
                        if (data_left != 0)
                            data_left--;
                        if (data_left == 0)
                            parse_phase = ndsp_pkg::PH_OPCODE;
                    end
                    default:
                        failed = 1'b1;
                endcase
            end
            if (!last)
                return;
            // truncated length or data leaves the phase off PH_OPCODE
            r.is_null_data = !failed && (parse_phase == ndsp_pkg::PH_OPCODE);
            r.push_count   = r.is_null_data ? 16'(pushes) : '0;
            expected_results.push_back(r);
            restart();
        endfunction

        // one accepted result transfer
        function void check_result(logic ok, logic [15:0] cnt);
            ndsp_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result is_null_data=%0b push_count=%0d",
                         $time, ok, cnt);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (ok !== want.is_null_data)
            begin
                $display("%0t: is_null_data expected %0b got %0b",
                         $time, want.is_null_data, ok);
                errors++;
            end
            if (cnt !== want.push_count)
            begin
                $display("%0t: push_count expected %0d got %0d",
                         $time, want.push_count, cnt);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals. Every block input starts at a known value.
    // ------------------------------------------------------------------
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  script_byte  = '0;
    logic        last_byte    = 1'b0;
    logic        empty_script = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        is_null_data;
    logic [15:0] push_count;

    // idle rates in percent, changed per stretch of the random part
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned sent_items   = 0;
    int unsigned cycle_count  = 0;

    // bytes of the script about to be sent
    logic [7:0]  script_q[$];

    null_data_tracker tracker = new;

    null_data_script_push_counter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .script_byte  (script_byte),
        .last_byte    (last_byte),
        .empty_script (empty_script),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_null_data (is_null_data),
        .push_count   (push_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: a correct run ends far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("null_data_script_push_counter_tb NOT OK");
            $finish;
        end
    end

    // Receiver: out_ready drops at random at the current stall rate.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_stall_pct);

    // Monitor: values read here are the ones just before the edge, so a
    // transfer is seen exactly at the edge that completes it. Inputs are
    // noted before outputs are checked in the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.note_byte(script_byte, last_byte, empty_script);
            if (out_valid && out_ready)
                tracker.check_result(is_null_data, push_count);
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // One input transfer. Idle cycles come first, so valid is never
    // lowered and raised at the same edge; once up it holds until taken.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic empty);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        script_byte  <= b;
        last_byte    <= last;
        empty_script <= empty;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
    endtask

    // Sends script_q; the last byte carries the mark unless the script is
    // abandoned, in which case an empty-script transfer follows instead.
    task automatic send_script(input bit abandon);
        int unsigned i;
        for (i = 0; i < script_q.size(); i++)
            send_byte(script_q[i], !abandon && (i == script_q.size() - 1), 1'b0);
        if (abandon)
            send_byte(8'($urandom), 1'($urandom), 1'b1);
    endtask

    // Appends one well-formed push element with random data.
    function automatic void add_push();
        int unsigned kind;
        int unsigned n;
        int unsigned i;
        logic [7:0]  op;
        kind = $urandom_range(0, 9);
        // mostly short pushes, now and then a long one
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 6);
        if (kind <= 3)
        begin
            if (n >= ndsp_pkg::LEN_PFX1)
                n = ndsp_pkg::LEN_PFX1 - 1;
            script_q.push_back(8'(n));
        end
        else if (kind <= 6)
        begin
            op = (kind == 4) ? ndsp_pkg::LEN_PFX1 :
                 (kind == 5) ? ndsp_pkg::LEN_PFX2 : ndsp_pkg::LEN_PFX4;
            script_q.push_back(op);
            script_q.push_back(8'(n));
            if (op != ndsp_pkg::LEN_PFX1)
                script_q.push_back(8'h00);
            if (op == ndsp_pkg::LEN_PFX4)
            begin
                script_q.push_back(8'h00);
                script_q.push_back(8'h00);
            end
        end
        else
        begin
            // no-data opcodes carry nothing after them
            script_q.push_back(8'($urandom_range(ndsp_pkg::NO_DATA_LO, ndsp_pkg::NO_DATA_HI)));
            n = 0;
        end
        for (i = 0; i < n; i++)
            script_q.push_back(8'($urandom));
    endfunction

    // One random script: mostly well formed, the rest broken on purpose.
    task automatic send_random_script();
        int unsigned mode;
        int unsigned k;
        script_q.delete();
        mode = $urandom_range(0, 99);
        if (mode >= 96)
        begin
            // plain noise or an empty script
            if ($urandom_range(1) == 1)
            begin
                send_byte(8'($urandom), 1'($urandom), 1'b1);
                return;
            end
            k = $urandom_range(1, 8);
            repeat (k) script_q.push_back(8'($urandom));
            send_script(1'b0);
            return;
        end
        script_q.push_back(ndsp_pkg::NULL_DATA_MARK);
        k = $urandom_range(0, 6);
        repeat (k) add_push();
        if (mode >= 92)
        begin
            send_script(1'b1);
            return;
        end
        if (mode >= 88)
        begin
            // opcode above the no-data range, trailing bytes must be ignored
            script_q.push_back(8'($urandom_range(ndsp_pkg::NO_DATA_HI + 1, 8'hff)));
            k = $urandom_range(0, 3);
            repeat (k) script_q.push_back(8'($urandom));
        end
        else if (mode >= 84)
            script_q[0] = ndsp_pkg::NULL_DATA_MARK ^ 8'($urandom_range(1, 255));
        else if (mode >= 78)
            script_q[$urandom_range(0, script_q.size() - 1)] = 8'($urandom);
        else if (mode >= 70 && script_q.size() > 1)
        begin
            // cut the tail: usually leaves length or data owed
            k = $urandom_range(1, script_q.size() - 1);
            repeat (k) void'(script_q.pop_back());
        end
        send_script(1'b0);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stretch;
        int unsigned goal;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling on either side
        send_byte(8'hff, 1'b1, 1'b1);                          // empty script
        script_q = '{ndsp_pkg::NULL_DATA_MARK};                // lone marker byte
        send_script(1'b0);
        script_q = '{8'hff};                                   // wrong first byte
        send_script(1'b0);
        script_q = '{ndsp_pkg::NULL_DATA_MARK, 8'h01, 8'h00};  // small push
        send_script(1'b0);
        script_q = '{ndsp_pkg::NULL_DATA_MARK, ndsp_pkg::LEN_PFX1, 8'h01, 8'haa,
                     ndsp_pkg::NO_DATA_LO, ndsp_pkg::NO_DATA_HI};
        send_script(1'b0);
        script_q = '{ndsp_pkg::NULL_DATA_MARK, ndsp_pkg::NO_DATA_HI + 8'h01}; // too high
        send_script(1'b0);
        script_q = '{ndsp_pkg::NULL_DATA_MARK, 8'h02, 8'h11};  // data cut short
        send_script(1'b0);
        script_q = '{ndsp_pkg::NULL_DATA_MARK, ndsp_pkg::LEN_PFX4, 8'h01}; // length cut short
        send_script(1'b0);
        script_q = '{ndsp_pkg::NULL_DATA_MARK, ndsp_pkg::LEN_PFX2, 8'h00, 8'h01}; // dropped
        send_script(1'b1);

        // random part, cycling through the idle profiles
        goal = sent_items;
        for (stretch = 0; stretch < STRETCHES; stretch++)
        begin
            case (stretch % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 56;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 56;
                end
                default:
                begin
                    tx_idle_pct  = 16;
                    rx_stall_pct = 16;
                end
            endcase
            goal += RANDOM_ITEMS / STRETCHES;
            while (sent_items < goal)
                send_random_script();
        end
        in_valid <= 1'b0;

        // drain, then watch a little longer for stray results
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0)
            $display("null_data_script_push_counter_tb OK");
        else
            $display("null_data_script_push_counter_tb NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ndsp_pkg.sv
rtl/ndsp_parse.sv
rtl/ndsp_out_reg.sv
rtl/null_data_script_push_counter.sv
tb/sv/null_data_script_push_counter_tb.sv
